// ===== sv/prt_pkg.sv =====
// shared types and constants of the pending request tracker
package prt_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned MSG_W    = 32;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned COOKIE_W = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CTR_W    = 10;
  localparam int unsigned RAND_W   = 22;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned PADDR_W  = 3;

  localparam logic [CNT_W-1:0]  CNT_MAX     = 5'd31;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd10000;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  localparam logic REG_TIMEOUT = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [KEY_W-1:0]    request_key;
    logic [MSG_W-1:0]    message_id;
    logic [KIND_W-1:0]   request_kind;
    logic [COOKIE_W-1:0] cookie_handle;
    logic [TIME_W-1:0]   now_ms;
    logic [RAND_W-1:0]   random_bits;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [KEY_W-1:0]    key_out;
    logic [MSG_W-1:0]    message_id_out;
    logic [KIND_W-1:0]   kind_out;
    logic [COOKIE_W-1:0] cookie_out;
    logic [TIME_W-1:0]   stamp_out;
    logic [CNT_W-1:0]    expired_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [MSG_W-1:0]    message;
    logic [KIND_W-1:0]   kind;
    logic [COOKIE_W-1:0] cookie;
    logic [TIME_W-1:0]   stamp;
  } entry_t;

  typedef struct packed {
    logic start;
    logic rd_en;
    logic commit;
  } prt_cmd_t;

  typedef struct packed {
    logic last_addr;
    logic out_free;
  } prt_stat_t;

endpackage

// ===== sv/prt_req_if.sv =====
// request channel interface
interface prt_req_if;
  logic          valid;
  logic          ready;
  prt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/prt_rsp_if.sv =====
// result channel interface
interface prt_rsp_if;
  logic          valid;
  logic          ready;
  prt_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/prt_ctrl.sv =====
// controller state machine sequencing accept, table scan and commit
module prt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  prt_pkg::prt_stat_t  stat_i,
  output prt_pkg::prt_cmd_t   cmd_o
);
  import prt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (stat_i.last_addr) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/prt_datapath.sv =====
// entry table, scan compare, rolling counter and result register
module prt_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  prt_pkg::prt_cmd_t               cmd_i,
  output prt_pkg::prt_stat_t              stat_o,
  input  prt_pkg::req_t                   req_i,
  input  logic [prt_pkg::TIME_W-1:0]      timeout_i,
  output logic                            rsp_valid_o,
  input  logic                            rsp_ready_i,
  output prt_pkg::rsp_t                   rsp_o
);
  import prt_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  entry_t mem [ENTRIES];

  logic [ENTRIES-1:0]  valid_q;
  logic [CTR_W-1:0]    ctr_q;
  logic [CTR_W-1:0]    ctr_inc;
  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [MSG_W-1:0]    msg_q;
  logic [KIND_W-1:0]   kind_q;
  logic [COOKIE_W-1:0] cookie_q;
  logic [TIME_W-1:0]   now_q;
  logic [IDX_W-1:0]    addr_q;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    rd_idx_q;
  entry_t              rd_data_q;
  logic                found_q;
  logic [IDX_W-1:0]    match_idx_q;
  entry_t              hit_q;
  logic                free_found_q;
  logic [IDX_W-1:0]    free_idx_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                rsp_valid_q;
  rsp_t                rsp_q;
  rsp_t                rsp_d;

  logic                hit;
  logic                free;
  logic                expire;
  logic [TIME_W-1:0]   expiry_sum;
  logic [IDX_W-1:0]    wr_idx;
  logic                mem_we;

  assign ctr_inc    = ctr_q + 1'b1;
  assign expiry_sum = rd_data_q.stamp + timeout_i;
  assign hit        = rd_vld_q && valid_q[rd_idx_q] && (rd_data_q.key == key_q);
  assign free       = rd_vld_q && !valid_q[rd_idx_q];
  assign expire     = rd_vld_q && valid_q[rd_idx_q] && (cmd_q == CMD_SWEEP)
                      && (expiry_sum < now_q);
  assign wr_idx     = found_q ? match_idx_q : free_idx_q;
  assign mem_we     = cmd_i.commit && (cmd_q == CMD_ADD) && (found_q || free_found_q);

  assign stat_o.last_addr = (addr_q == LAST_IDX);
  assign stat_o.out_free  = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o      = rsp_valid_q;
  assign rsp_o            = rsp_q;

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= '{key: key_q, message: msg_q, kind: kind_q, cookie: cookie_q,
                       stamp: now_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[addr_q];
    end
  end

  // request fields, scan captures and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q    <= req_i.command;
      key_q    <= (req_i.command == CMD_ADD) ? {req_i.random_bits, ctr_inc}
                                             : req_i.request_key;
      msg_q    <= req_i.message_id;
      kind_q   <= req_i.request_kind;
      cookie_q <= req_i.cookie_handle;
      now_q    <= req_i.now_ms;
    end
    rd_idx_q <= addr_q;
    if (hit && !found_q) begin
      match_idx_q <= rd_idx_q;
      hit_q       <= rd_data_q;
    end
    if (free && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      ctr_q        <= '0;
      addr_q       <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      cnt_q        <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.start) begin
        addr_q       <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
        cnt_q        <= '0;
        if (req_i.command == CMD_ADD) begin
          ctr_q <= ctr_inc;
        end
      end else begin
        if (cmd_i.rd_en) begin
          addr_q <= addr_q + 1'b1;
        end
        if (hit) begin
          found_q <= 1'b1;
        end
        if (free) begin
          free_found_q <= 1'b1;
        end
        if (expire && (cnt_q != CNT_MAX)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (expire) begin
        valid_q[rd_idx_q] <= 1'b0;
      end
      if (mem_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.commit && (cmd_q == CMD_REMOVE) && found_q) begin
        valid_q[match_idx_q] <= 1'b0;
      end
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_comb begin
    rsp_d = '0;
    unique case (cmd_q)
      CMD_ADD: begin
        rsp_d.key_out = key_q;
        if (found_q || free_found_q) begin
          rsp_d.message_id_out = msg_q;
          rsp_d.kind_out       = kind_q;
          rsp_d.cookie_out     = cookie_q;
          rsp_d.stamp_out      = now_q;
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      CMD_FIND, CMD_REMOVE: begin
        rsp_d.key_out = key_q;
        if (found_q) begin
          rsp_d.message_id_out = hit_q.message;
          rsp_d.kind_out       = hit_q.kind;
          rsp_d.cookie_out     = hit_q.cookie;
          rsp_d.stamp_out      = hit_q.stamp;
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      CMD_SWEEP: begin
        rsp_d.expired_count = cnt_q;
      end
    endcase
  end

endmodule

// ===== sv/pending_request_tracker_core.sv =====
// top level of the pending request tracker
//
// Tracks up to ENTRIES outstanding requests by key. Commands arrive on the
// req channel (add, find, remove, sweep) and each produces exactly one
// result transfer on the rsp channel. The expiry timeout is a register on
// the APB port at byte address 0; write it only while no command is in
// flight.
//
// Every command walks the whole table through the single read port of the
// entry memory, one entry per cycle, then commits: it passes through the
// scan, drain and done states, and the result register is loaded at the
// commit in the done state, before the next accept. One command is handled
// at a time.
//
// The result sits in an output register; the next command is accepted while
// it waits. If the receiver stalls, the following command holds in its
// final step until the register is taken.
//
// Reset clears all valid bits, the rolling key counter and the timeout
// (to 10000 ms); no clearing pass is needed.
module pending_request_tracker_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  prt_req_if.sink                          req,
  prt_rsp_if.source                        rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [prt_pkg::PADDR_W-1:0]      paddr,
  input  logic [prt_pkg::PDATA_W-1:0]      pwdata,
  output logic [prt_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import prt_pkg::*;

  prt_cmd_t            cmd;
  prt_stat_t           stat;
  logic [TIME_W-1:0]   timeout_q;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_TIMEOUT);
  assign prdata  = reg_sel ? timeout_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      timeout_q <= pwdata;
    end
  end

  prt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  prt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (req.data),
    .timeout_i   (timeout_q),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .rsp_o       (rsp.data)
  );

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second transfer accepted while a command is in flight");

  a_commit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!rsp.valid || rsp.ready))
    else $error("commit would overwrite an untaken result");

  a_commit_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> rsp.valid)
    else $error("committed result not presented");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && (rsp.data.status != ST_OK)) |->
      (rsp.data.message_id_out == '0) && (rsp.data.stamp_out == '0)
      && (rsp.data.expired_count == '0))
    else $error("failed command carries entry data");

endmodule

// ===== verif/prt_tracker_checker.sv =====
// checker for the pending request tracker: mirrors the table and compares every result transfer
module prt_tracker_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  prt_req_if                           req,
  prt_rsp_if                           rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prt_pkg::PADDR_W-1:0]  paddr,
  input  logic [prt_pkg::PDATA_W-1:0]  pwdata,
  input  logic                         pready,
  output int unsigned                  mismatch_o,
  output int unsigned                  checked_o,
  output int unsigned                  owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import prt_pkg::*;

  localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

  entry_t            slots [ENTRIES];
  logic              live  [ENTRIES];
  logic [CTR_W-1:0]  key_ctr;
  logic [TIME_W-1:0] expiry_ms;
  rsp_t              owed_results [$];
  int unsigned       mismatch_n;
  int unsigned       checked_n;

  function automatic int find_live(input logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (live[i] && slots[i].key == key) return i;
    end
    return -1;
  endfunction

  function automatic rsp_t apply_command(input req_t r);
    rsp_t              res;
    int                at;
    int                i;
    logic [TIME_W-1:0] deadline;
    res        = '0;
    res.status = ST_OK;
    at         = -1;
    if (r.command == CMD_ADD) begin
      key_ctr     = key_ctr + 1'b1;
      res.key_out = {r.random_bits, key_ctr};
      at          = find_live(res.key_out);
      // lowest free slot when the key is new
      for (i = 0; i < ENTRIES && at < 0; i++) begin
        if (!live[i]) at = i;
      end
      if (at < 0) begin
        res.status = ST_FULL;
      end else begin
        live[at]         = 1'b1;
        slots[at].key    = res.key_out;
        slots[at].message = r.message_id;
        slots[at].kind   = r.request_kind;
        slots[at].cookie = r.cookie_handle;
        slots[at].stamp  = r.now_ms;
      end
    end else if (r.command == CMD_SWEEP) begin
      for (i = 0; i < ENTRIES; i++) begin
        deadline = slots[i].stamp + expiry_ms;
        if (live[i] && deadline < r.now_ms) begin
          live[i] = 1'b0;
          if (res.expired_count != CNT_MAX) res.expired_count++;
        end
      end
    end else begin
      res.key_out = r.request_key;
      at          = find_live(r.request_key);
      if (at < 0) res.status = ST_NOT_FOUND;
    end
    if (at >= 0 && res.status == ST_OK) begin
      res.message_id_out = slots[at].message;
      res.kind_out       = slots[at].kind;
      res.cookie_out     = slots[at].cookie;
      res.stamp_out      = slots[at].stamp;
      if (r.command == CMD_REMOVE) live[at] = 1'b0;
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_n++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    int   i;
    if (!rst_ni) begin
      for (i = 0; i < ENTRIES; i++) live[i] = 1'b0;
      key_ctr    = '0;
      expiry_ms  = TIMEOUT_RST;
      owed_results.delete();
      mismatch_n = 0;
      checked_n  = 0;
      mismatch_o <= 0;
      checked_o  <= 0;
      owed_o     <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == TIMEOUT_ADDR) expiry_ms = pwdata;
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          mismatch_n++;
          $error("result transfer with no command outstanding");
        end else begin
          want = owed_results.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.data.status));
          check_field("key_out", want.key_out, rsp.data.key_out);
          check_field("message_id_out", want.message_id_out, rsp.data.message_id_out);
          check_field("kind_out", 32'(want.kind_out), 32'(rsp.data.kind_out));
          check_field("cookie_out", want.cookie_out, rsp.data.cookie_out);
          check_field("stamp_out", want.stamp_out, rsp.data.stamp_out);
          check_field("expired_count", 32'(want.expired_count), 32'(rsp.data.expired_count));
          checked_n++;
        end
      end
      if (req.valid && req.ready) owed_results.push_back(apply_command(req.data));
      mismatch_o <= mismatch_n;
      checked_o  <= checked_n;
      owed_o     <= owed_results.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// top of the pending request tracker testbench: clock, reset, stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prt_pkg::*;

  localparam int unsigned       DEPTH        = 16;
  localparam int unsigned       CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned       IDLE_PCT     = 27;
  localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  prt_req_if req_if ();
  prt_rsp_if rsp_if ();

  int unsigned mismatch_n;
  int unsigned checked_n;
  int unsigned owed_n;
  int unsigned cycle_n = 0;

  int unsigned sent_n    = 0;
  int unsigned adds_n    = 0;
  int unsigned finds_n   = 0;
  int unsigned removes_n = 0;
  int unsigned sweeps_n  = 0;

  logic                steady;
  logic                hold_active;
  logic                pin_hit;
  logic [CTR_W-1:0]    ctr_sent;
  logic [CTR_W-1:0]    pin_ctr;
  logic [RAND_W-1:0]   pin_rand;
  logic [KEY_W-1:0]    pin_key;
  logic [KEY_W-1:0]    last_key;
  logic [TIME_W-1:0]   clock_ms;
  logic [TIME_W-1:0]   spare_timeout;
  logic [RAND_W-1:0]   rand_used [1 << CTR_W];
  bit                  rand_seen [1 << CTR_W];
  logic [KEY_W-1:0]    recent [$];

  pending_request_tracker_core #(
    .ENTRIES (DEPTH)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  prt_tracker_checker #(
    .ENTRIES (DEPTH)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_if),
    .rsp        (rsp_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatch_o (mismatch_n),
    .checked_o  (checked_n),
    .owed_o     (owed_n)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("FAIL pending_request_tracker_core");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic req_t make_req(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                    input logic [TIME_W-1:0] now);
    req_t r;
    r.command       = cmd;
    r.request_key   = key;
    r.message_id    = $urandom();
    r.request_kind  = KIND_W'($urandom());
    r.cookie_handle = $urandom();
    r.now_ms        = now;
    r.random_bits   = RAND_W'($urandom());
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if (recent.size() != 0 && $urandom_range(3) != 0)
      return recent[$urandom_range(recent.size() - 1)];
    return $urandom();
  endfunction

  function automatic logic [TIME_W-1:0] pick_now();
    clock_ms = clock_ms + $urandom_range(2500);
    if ($urandom_range(99) < 15) return $urandom();
    return clock_ms;
  endfunction

  task automatic issue(input req_t r);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, DEPTH + 6);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sent_n++;
    unique case (r.command)
      CMD_ADD: begin
        ctr_sent            = ctr_sent + 1'b1;
        last_key            = {r.random_bits, ctr_sent};
        rand_used[ctr_sent] = r.random_bits;
        rand_seen[ctr_sent] = 1'b1;
        recent.push_back(last_key);
        if (recent.size() > 32) void'(recent.pop_front());
        adds_n++;
      end
      CMD_FIND:   finds_n++;
      CMD_REMOVE: removes_n++;
      default:    sweeps_n++;
    endcase
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (checked_n != sent_n) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [TIME_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_item(input int unsigned add_pct);
    req_t             r;
    int unsigned      roll;
    logic [CTR_W-1:0] ctr;
    r    = make_req(CMD_FIND, pick_key(), pick_now());
    roll = $urandom_range(99);
    ctr  = ctr_sent + 1'b1;
    if (roll < add_pct) begin
      r.command = CMD_ADD;
      if (hold_active && ctr == pin_ctr) begin
        r.random_bits = pin_rand;
        pin_hit       = 1'b1;
      end else if (rand_seen[ctr] && $urandom_range(3) == 0) begin
        r.random_bits = rand_used[ctr];
      end
    end else if (roll < add_pct + 8) begin
      r.command = CMD_SWEEP;
    end else if ($urandom_range(1) == 1) begin
      r.command = CMD_REMOVE;
      if (hold_active && r.request_key == pin_key) r.request_key = ~pin_key;
    end
    issue(r);
  endtask

  task automatic run_directed();
    req_t             r;
    logic [KEY_W-1:0] ones_key;
    logic [KEY_W-1:0] zero_key;
    int unsigned      i;
    issue(make_req(CMD_FIND, '0, '0));
    issue(make_req(CMD_REMOVE, '1, '1));
    issue(make_req(CMD_SWEEP, '0, '1));
    r               = make_req(CMD_ADD, '0, '1);
    r.message_id    = '1;
    r.request_kind  = '1;
    r.cookie_handle = '1;
    r.random_bits   = '1;
    issue(r);
    ones_key        = last_key;
    r               = make_req(CMD_ADD, '1, '0);
    r.message_id    = '0;
    r.request_kind  = '0;
    r.cookie_handle = '0;
    r.random_bits   = '0;
    issue(r);
    zero_key        = last_key;
    issue(make_req(CMD_FIND, ones_key, '0));
    issue(make_req(CMD_REMOVE, zero_key, '0));
    issue(make_req(CMD_FIND, zero_key, '0));
    // fill the table, the last add finds it full
    for (i = 1; i <= DEPTH; i++) issue(make_req(CMD_ADD, '0, TIME_W'(100 * i)));
    // stamp 100 and the wrapped all-ones stamp expire, stamp 200 sits on the boundary
    issue(make_req(CMD_SWEEP, '0, TIME_W'(10200)));
    issue(make_req(CMD_ADD, '0, '0));
    issue(make_req(CMD_ADD, '0, '0));
    issue(make_req(CMD_SWEEP, '0, '1));
  endtask

  // keep one key alive until the counter wraps, then add it again
  task automatic hold_phase();
    int unsigned n;
    issue(make_req(CMD_ADD, '0, '0));
    pin_key     = last_key;
    pin_ctr     = ctr_sent;
    pin_rand    = last_key[KEY_W-1:CTR_W];
    pin_hit     = 1'b0;
    hold_active = 1'b1;
    n           = 0;
    while (!pin_hit) begin
      steady <= (n >= 200 && n < 500);
      random_item(70);
      n++;
    end
    hold_active = 1'b0;
    steady <= 1'b0;
    issue(make_req(CMD_FIND, pin_key, clock_ms));
  endtask

  initial begin
    rst_ni        <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.data   <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    steady        <= 1'b0;
    hold_active   = 1'b0;
    pin_hit       = 1'b0;
    ctr_sent      = '0;
    clock_ms      = '0;
    spare_timeout = $urandom();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain();
    write_timeout('0);
    repeat (150) random_item(45);
    issue(make_req(CMD_SWEEP, '0, '1));
    drain();
    write_timeout('1);
    hold_phase();
    drain();
    write_timeout(32'h7fff_ffff);
    repeat (150) random_item(45);
    drain();
    write_timeout(spare_timeout);
    repeat (150) random_item(45);
    drain();
    repeat (DEPTH + 4) @(posedge clk_i);

    $display("%0d commands (%0d add, %0d find, %0d remove, %0d sweep), %0d results compared",
             sent_n, adds_n, finds_n, removes_n, sweeps_n, checked_n);
    $display("timeouts: reset value, 0, all ones, 0x7fffffff, 0x%08h; held key re-added after wrap",
             spare_timeout);
    if (mismatch_n == 0 && owed_n == 0) begin
      $display("PASS pending_request_tracker_core");
    end else begin
      $display("FAIL pending_request_tracker_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/prt_pkg.sv
sv/prt_req_if.sv
sv/prt_rsp_if.sv
sv/prt_ctrl.sv
sv/prt_datapath.sv
sv/pending_request_tracker_core.sv
verif/prt_tracker_checker.sv
verif/tb.sv
